/* sv/kts_pkg.sv */
`default_nettype none
package kts_pkg;

  localparam int MAX_KEYS = 64;
  localparam int IDX_W    = $clog2(MAX_KEYS);
  localparam int CNT_W    = $clog2(MAX_KEYS + 1);
  localparam int CFG_W    = 7;
  localparam int SLOT_W   = 6;
  localparam int FRAC_W   = 16;

  typedef enum logic [2:0] {
    ST_WRITTEN  = 3'd0,
    ST_INTERP   = 3'd1,
    ST_SINGLE   = 3'd2,
    ST_PAST     = 3'd3,
    ST_BEFORE   = 3'd4,
    ST_ZERO_GAP = 3'd5
  } status_e;

  typedef struct packed {
    logic        [31:0] ktime;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } key_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    key_t              key;
  } wr_t;

  typedef struct packed {
    logic        valid;
    logic        done;
    status_e     stat;
    logic [31:0] t;
    key_t        start_k;
    key_t        end_k;
  } token_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    status_e            stat;
  } res_t;

endpackage
`default_nettype wire

/* sv/kts_cell.sv */
`default_nettype none
module kts_cell (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [kts_pkg::IDX_W-1:0] idx_i,
  input  wire logic [kts_pkg::CNT_W-1:0] n_i,
  input  wire kts_pkg::wr_t              wr_i,
  input  wire kts_pkg::token_t           tok_i,
  output kts_pkg::token_t                tok_o
);
  import kts_pkg::*;

  key_t   key_q;
  token_t tok_d, tok_q;
  logic   valid_q;

  // Cell zero screens the single-key and before-first cases; every other cell
  // in use tests whether the sample time falls before its own key.
  always_comb begin
    tok_d = tok_i;
    if (tok_i.valid && !tok_i.done) begin
      if (idx_i == '0) begin
        tok_d.start_k = key_q;
        if (n_i == CNT_W'(1)) begin
          tok_d.done = 1'b1;
          tok_d.stat = ST_SINGLE;
        end else if (tok_i.t < key_q.ktime) begin
          tok_d.done = 1'b1;
          tok_d.stat = ST_BEFORE;
        end
      end else if (idx_i < n_i) begin
        if (tok_i.t < key_q.ktime) begin
          tok_d.done  = 1'b1;
          tok_d.stat  = ST_INTERP;
          tok_d.end_k = key_q;
        end else begin
          tok_d.start_k = key_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en && (int'(wr_i.slot) == int'(idx_i))) begin
      key_q <= wr_i.key;
    end
    tok_q <= tok_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= tok_i.valid;
    end
  end

  always_comb begin
    tok_o       = tok_q;
    tok_o.valid = valid_q;
  end

endmodule
`default_nettype wire

/* sv/kts_lerp.sv */
`default_nettype none
module kts_lerp (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire kts_pkg::token_t tok_i,
  input  wire logic            take_i,
  output logic                 res_valid_o,
  output kts_pkg::res_t        res_o
);
  import kts_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_MUL, S_DONE} state_e;

  state_e             state_q;
  key_t               start_q, end_q;
  logic [31:0]        rem_q;
  logic [FRAC_W-1:0]  quo_q;
  logic [3:0]         cnt_q;
  logic [1:0]         comp_q;
  res_t               res_q;

  logic [31:0]        gap;
  logic [32:0]        rem2, rem_sub;
  logic               ge;
  logic signed [31:0] a, b, sum;
  logic signed [32:0] d;
  logic signed [49:0] prod;

  // Restoring divide: one quotient bit per cycle.
  assign gap     = end_q.ktime - start_q.ktime;
  assign rem2    = {rem_q, 1'b0};
  assign rem_sub = rem2 - {1'b0, gap};
  assign ge      = rem2 >= {1'b0, gap};

  always_comb begin
    case (comp_q)
      2'd0:    begin a = start_q.x; b = end_q.x; end
      2'd1:    begin a = start_q.y; b = end_q.y; end
      2'd2:    begin a = start_q.z; b = end_q.z; end
      default: begin a = start_q.x; b = end_q.x; end
    endcase
  end

  // The exact product shifted right arithmetically gives the floor.
  assign d    = {b[31], b} - {a[31], a};
  assign prod = d * $signed({1'b0, quo_q});
  assign sum  = a + $signed(prod[47:16]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      start_q <= '0;
      end_q   <= '0;
      rem_q   <= '0;
      quo_q   <= '0;
      cnt_q   <= '0;
      comp_q  <= '0;
      res_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (tok_i.valid) begin
            start_q   <= tok_i.start_k;
            end_q     <= tok_i.end_k;
            rem_q     <= tok_i.t - tok_i.start_k.ktime;
            cnt_q     <= '0;
            comp_q    <= '0;
            res_q.x   <= tok_i.start_k.x;
            res_q.y   <= tok_i.start_k.y;
            res_q.z   <= tok_i.start_k.z;
            state_q   <= S_DONE;
            if (!tok_i.done) begin
              res_q.stat <= ST_PAST;
            end else if (tok_i.stat != ST_INTERP) begin
              res_q.stat <= tok_i.stat;
            end else if (tok_i.end_k.ktime <= tok_i.start_k.ktime ||
                         tok_i.t < tok_i.start_k.ktime) begin
              res_q.stat <= ST_ZERO_GAP;
            end else begin
              res_q.stat <= ST_INTERP;
              state_q    <= S_DIV;
            end
          end
        end
        S_DIV: begin
          rem_q <= ge ? rem_sub[31:0] : rem2[31:0];
          quo_q <= {quo_q[FRAC_W-2:0], ge};
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'(FRAC_W - 1)) begin
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          case (comp_q)
            2'd0:    res_q.x <= sum;
            2'd1:    res_q.y <= sum;
            default: res_q.z <= sum;
          endcase
          comp_q <= comp_q + 2'd1;
          if (comp_q == 2'd2) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (take_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

endmodule
`default_nettype wire

/* sv/keyframe_track_sampler.sv */
`default_nettype none
// Channel   Handshake                  Payload
// input     in_valid_i / in_ready_o    cmd_i, key_slot_i, key_time_i, key_x/y/z_i,
//                                      sample_time_i
// output    out_valid_o / out_ready_i  out_x_o, out_y_o, out_z_o, status_o
// config    cfg_we_i                   cfg_wdata_i (keys in use)
//
// A write item is loaded into the output register at the edge that accepts it.
// A sample item walks the chain of key cells one cell per cycle and is captured by
// the interpolator; an interpolated sample then passes through the restoring
// divider and the shared multiplier before its result is registered, while a
// clamped answer is registered straight from the captured token.
// Reset clears the control state and sets keys in use to one; key storage is
// undefined until written. A stalled output holds its item, and no new item is
// taken while a sample is in flight or the output cannot be freed.
module keyframe_track_sampler (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         cmd_i,
  input  wire logic [kts_pkg::SLOT_W-1:0]   key_slot_i,
  input  wire logic [31:0]                  key_time_i,
  input  wire logic signed [31:0]           key_x_i,
  input  wire logic signed [31:0]           key_y_i,
  input  wire logic signed [31:0]           key_z_i,
  input  wire logic [31:0]                  sample_time_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic signed [31:0]                out_x_o,
  output logic signed [31:0]                out_y_o,
  output logic signed [31:0]                out_z_o,
  output logic [2:0]                        status_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [kts_pkg::CFG_W-1:0]    cfg_wdata_i
);
  import kts_pkg::*;

  logic [CFG_W-1:0] keys_q;
  logic [CNT_W-1:0] n;
  logic             busy_q, out_valid_q, free, accept, take;
  res_t             out_q, lerp_res;
  logic             lerp_valid;
  wr_t              wr;
  token_t           tok [MAX_KEYS+1];

  // The register value is clamped into the range of cells that exist.
  always_comb begin
    if (keys_q == '0) begin
      n = CNT_W'(1);
    end else if (int'(keys_q) > MAX_KEYS) begin
      n = CNT_W'(MAX_KEYS);
    end else begin
      n = CNT_W'(keys_q);
    end
  end

  assign free       = !out_valid_q || out_ready_i;
  assign in_ready_o = !busy_q && free;
  assign accept     = in_valid_i && in_ready_o;
  assign take       = lerp_valid && free;

  assign wr.en        = accept && !cmd_i;
  assign wr.slot      = key_slot_i;
  assign wr.key.ktime = key_time_i;
  assign wr.key.x     = key_x_i;
  assign wr.key.y     = key_y_i;
  assign wr.key.z     = key_z_i;

  // A sample item enters the chain as a token at cell zero.
  always_comb begin
    tok[0]       = '0;
    tok[0].valid = accept && cmd_i;
    tok[0].t     = sample_time_i;
  end

  for (genvar g = 0; g < MAX_KEYS; g++) begin : g_cell
    kts_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (IDX_W'(g)),
      .n_i    (n),
      .wr_i   (wr),
      .tok_i  (tok[g]),
      .tok_o  (tok[g+1])
    );
  end

  kts_lerp u_lerp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_i       (tok[MAX_KEYS]),
    .take_i      (take),
    .res_valid_o (lerp_valid),
    .res_o       (lerp_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keys_q      <= CFG_W'(1);
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        keys_q <= cfg_wdata_i;
      end
      if (accept && cmd_i) begin
        busy_q <= 1'b1;
      end else if (take) begin
        busy_q <= 1'b0;
      end
      if (wr.en || take) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload; a write item reports zero values.
  always_ff @(posedge clk_i) begin
    if (wr.en) begin
      out_q      <= '0;
      out_q.stat <= ST_WRITTEN;
    end else if (take) begin
      out_q <= lerp_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_q.x;
  assign out_y_o     = out_q.y;
  assign out_z_o     = out_q.z;
  assign status_o    = out_q.stat;

endmodule
`default_nettype wire

/* sv/kts_checker.sv */
`default_nettype none
module kts_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_ready_o,
  input wire logic                       cmd_i,
  input wire logic                       out_valid_o,
  input wire logic                       out_ready_i,
  input wire logic signed [31:0]         out_x_o,
  input wire logic signed [31:0]         out_y_o,
  input wire logic signed [31:0]         out_z_o,
  input wire logic [2:0]                 status_o
);
  import kts_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output item dropped while stalled");

  a_write_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !cmd_i |=> out_valid_o && status_o == ST_WRITTEN)
    else $error("write item did not report at once");

  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && cmd_i |=> !in_ready_o)
    else $error("new item taken while a sample is in flight");

  a_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_WRITTEN |->
      out_x_o == 0 && out_y_o == 0 && out_z_o == 0)
    else $error("write result carries nonzero values");

endmodule

bind keyframe_track_sampler kts_checker u_kts_checker (.*);
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import kts_pkg::*;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;
  localparam int   ITEM_GOAL  = 1550;
  localparam int   CYCLE_LIMIT = 4000000;

  typedef struct {
    logic        cmd;
    logic [5:0]  slot;
    logic [31:0] ktime;
    logic [31:0] kx;
    logic [31:0] ky;
    logic [31:0] kz;
    logic [31:0] stime;
  } track_item_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic              cmd_i = 1'b0;
  logic [SLOT_W-1:0] key_slot_i = '0;
  logic [31:0]       key_time_i = '0;
  logic [31:0]       key_x_i = '0;
  logic [31:0]       key_y_i = '0;
  logic [31:0]       key_z_i = '0;
  logic [31:0]       sample_time_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [31:0]       out_x_o;
  logic [31:0]       out_y_o;
  logic [31:0]       out_z_o;
  logic [2:0]        status_o;
  logic              cfg_we_i = 1'b0;
  logic [CFG_W-1:0]  cfg_wdata_i = '0;

  keyframe_track_sampler dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .key_slot_i    (key_slot_i),
    .key_time_i    (key_time_i),
    .key_x_i       (key_x_i),
    .key_y_i       (key_y_i),
    .key_z_i       (key_z_i),
    .sample_time_i (sample_time_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_x_o       (out_x_o),
    .out_y_o       (out_y_o),
    .out_z_o       (out_z_o),
    .status_o      (status_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Items waiting to be driven, and the results the track model says are due.
  track_item_t pending_items[$];
  res_t        due_results[$];

  // Our own copy of the track and of the keys-in-use register.
  logic [31:0] trk_time [MAX_KEYS];
  logic [31:0] trk_x [MAX_KEYS];
  logic [31:0] trk_y [MAX_KEYS];
  logic [31:0] trk_z [MAX_KEYS];
  logic [CFG_W-1:0] keys_used;

  // The stimulus generator's view of key times, updated as items are queued.
  logic [31:0] plan_time [MAX_KEYS];

  int errors;
  int cycles;
  int samples_seen;
  int interp_seen;
  int edge_seen;
  bit no_idle;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // The run is stopped here if the block hangs.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one; none while no_idle is set.
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 60) return 0;
    if (roll < 94) return $urandom_range(1, 3);
    return $urandom_range(20, 150);
  endfunction

  // One interpolated component: start plus floor(factor * (end - start) / 2^16).
  // The product stays below 2^50, so a signed 64-bit shift gives the floor.
  function automatic logic [31:0] blend(logic [31:0] a, logic [31:0] b, longint f);
    longint s;
    longint d;
    longint p;
    s = longint'($signed(a));
    d = longint'($signed(b)) - s;
    p = d * f;
    return 32'(s + (p >>> 16));
  endfunction

  function automatic res_t key_result(int k, status_e st);
    res_t r;
    r.x = trk_x[k];
    r.y = trk_y[k];
    r.z = trk_z[k];
    r.stat = st;
    return r;
  endfunction

  // Applies one accepted item to the track copy and returns its result.
  function automatic res_t track_eval(track_item_t it);
    res_t        r;
    int          n;
    int          seg;
    bit          found;
    logic [31:0] t0;
    logic [31:0] t1;
    logic [63:0] span;
    logic [63:0] factor;
    r = '{x: '0, y: '0, z: '0, stat: ST_WRITTEN};
    found = 1'b0;
    seg = 0;
    if (it.cmd == CMD_WRITE) begin
      trk_time[it.slot] = it.ktime;
      trk_x[it.slot] = it.kx;
      trk_y[it.slot] = it.ky;
      trk_z[it.slot] = it.kz;
      return r;
    end
    // Keys in use of zero counts as one; anything above the store size saturates.
    n = keys_used;
    if (n < 1) n = 1;
    if (n > MAX_KEYS) n = MAX_KEYS;
    if (n == 1) return key_result(0, ST_SINGLE);
    if (it.stime < trk_time[0]) return key_result(0, ST_BEFORE);
    for (int i = 0; i + 1 < n; i++) begin
      if (it.stime < trk_time[i+1]) begin
        seg = i;
        found = 1'b1;
        break;
      end
    end
    if (!found) return key_result(n - 1, ST_PAST);
    t0 = trk_time[seg];
    t1 = trk_time[seg+1];
    if (t1 <= t0 || it.stime < t0) return key_result(seg, ST_ZERO_GAP);
    span = 64'(t1) - 64'(t0);
    factor = ((64'(it.stime) - 64'(t0)) << 16) / span;
    if (factor > 64'hFFFF) factor = 64'hFFFF;
    r.x = blend(trk_x[seg], trk_x[seg+1], longint'(factor));
    r.y = blend(trk_y[seg], trk_y[seg+1], longint'(factor));
    r.z = blend(trk_z[seg], trk_z[seg+1], longint'(factor));
    r.stat = ST_INTERP;
    return r;
  endfunction

  // Input driver: predicts on acceptance, then holds, idles or loads the next item.
  int in_idle;
  always @(posedge clk_i) begin
    track_item_t it;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        it = '{cmd_i, key_slot_i, key_time_i, key_x_i, key_y_i, key_z_i, sample_time_i};
        due_results.push_back(track_eval(it));
      end
      if (in_valid_i && !in_ready_o) begin
        in_valid_i <= 1'b1;
      end else if (in_idle > 0) begin
        in_idle = in_idle - 1;
        in_valid_i <= 1'b0;
      end else if (pending_items.size() > 0) begin
        it = pending_items.pop_front();
        cmd_i <= it.cmd;
        key_slot_i <= it.slot;
        key_time_i <= it.ktime;
        key_x_i <= it.kx;
        key_y_i <= it.ky;
        key_z_i <= it.kz;
        sample_time_i <= it.stime;
        in_valid_i <= 1'b1;
        in_idle = idle_len();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output monitor: checks each accepted result against the oldest prediction
  // and stalls the block at random.
  int out_stall;
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (due_results.size() == 0) begin
          $error("result with nothing expected: status %0d", status_o);
          errors++;
        end else begin
          want = due_results.pop_front();
          if (out_x_o !== want.x) begin
            $error("out_x: expected %0d, got %0d", $signed(want.x), $signed(out_x_o));
            errors++;
          end
          if (out_y_o !== want.y) begin
            $error("out_y: expected %0d, got %0d", $signed(want.y), $signed(out_y_o));
            errors++;
          end
          if (out_z_o !== want.z) begin
            $error("out_z: expected %0d, got %0d", $signed(want.z), $signed(out_z_o));
            errors++;
          end
          if (status_o !== want.stat) begin
            $error("status: expected %0d, got %0d", want.stat, status_o);
            errors++;
          end
          if (want.stat != ST_WRITTEN) samples_seen++;
          if (want.stat == ST_INTERP) interp_seen++;
          if (want.stat == ST_BEFORE || want.stat == ST_PAST) edge_seen++;
        end
      end
      if (out_stall > 0) begin
        out_stall = out_stall - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_stall = idle_len();
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic track_item_t write_item(int slot, logic [31:0] t,
                                             logic [31:0] x, logic [31:0] y,
                                             logic [31:0] z);
    track_item_t it;
    it = '{CMD_WRITE, 6'(slot), t, x, y, z, $urandom()};
    return it;
  endfunction

  function automatic track_item_t sample_item(logic [31:0] t);
    track_item_t it;
    it = '{CMD_SAMPLE, 6'($urandom()), $urandom(), $urandom(), $urandom(), $urandom(), t};
    return it;
  endfunction

  // Values mostly random, sometimes at the extremes of the signed range.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 1000) - 500;
      default: return $urandom();
    endcase
  endfunction

  int queued;

  task automatic queue_item(track_item_t it);
    if (it.cmd == CMD_WRITE) plan_time[it.slot] = it.ktime;
    pending_items.push_back(it);
    queued++;
  endtask

  // Waits until the block has nothing in flight, then writes keys in use.
  task automatic set_keys_used(logic [CFG_W-1:0] v);
    while (pending_items.size() > 0 || in_valid_i || due_results.size() > 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    keys_used = v;
    cfg_we_i <= 1'b0;
  endtask

  // Sample times: mostly inside a segment of the planned track, also exact key
  // times, points outside the track and the ends of the time range.
  function automatic logic [31:0] pick_sample(int n);
    int k;
    logic [31:0] lo;
    logic [31:0] hi;
    k = $urandom_range(0, (n > 1) ? n - 2 : 0);
    lo = plan_time[k];
    hi = plan_time[(n > 1) ? k + 1 : 0];
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return plan_time[$urandom_range(0, n - 1)];
      3: return $urandom();
      4: return (plan_time[0] > 0) ? plan_time[0] - 1 : 32'h0;
      default: begin
        if (hi > lo) return lo + 32'($urandom_range(0, 32'(hi - lo - 1)));
        return lo;
      end
    endcase
  endfunction

  initial begin
    int n;
    int nsamp;
    logic [CFG_W-1:0] cfg;
    logic [32:0] acc;
    keys_used = 1;
    errors = 0;
    cycles = 0;
    queued = 0;
    no_idle = 1'b0;
    in_idle = 0;
    out_stall = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. A single key answers with its own value whatever the time.
    queue_item(write_item(0, 32'h0000_0100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0));
    queue_item(write_item(1, 32'h0000_0200, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
    queue_item(write_item(63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF));
    queue_item(sample_item(32'h0));
    queue_item(sample_item(32'hFFFF_FFFF));
    // Two keys: before the first, exactly on it, inside, just short of and
    // past the second, with full-scale value swings on the x and y components.
    set_keys_used(7'd2);
    foreach (plan_time[i]) if (i >= 2) plan_time[i] = '0;
    queue_item(sample_item(32'h0));
    queue_item(sample_item(32'h0000_0100));
    queue_item(sample_item(32'h0000_0180));
    queue_item(sample_item(32'h0000_01FF));
    queue_item(sample_item(32'h0000_0200));
    queue_item(sample_item(32'hFFFF_FFFF));
    // A segment spanning the whole time range, and the top slot as the last key
    // once keys in use saturates.
    queue_item(write_item(0, 32'h0, 32'h1, 32'h8000_0000, 32'h7FFF_FFFF));
    queue_item(write_item(1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
    queue_item(sample_item(32'h8000_0000));
    queue_item(sample_item(32'hFFFF_FFFE));
    for (int i = 2; i < 63; i++)
      queue_item(write_item(i, 32'hFFFF_FFFF, $urandom(), $urandom(), $urandom()));
    set_keys_used(7'd127);
    queue_item(sample_item(32'hFFFF_FFFF));
    set_keys_used(7'd0);
    queue_item(sample_item(32'h1234_5678));

    // Random phases: pick a register value, lay down a track over the keys in
    // use, then sample it, with a few stray writes mixed in.
    while (queued < ITEM_GOAL) begin
      case ($urandom_range(0, 9))
        0: cfg = 7'd1;
        1: cfg = 7'd64;
        2: cfg = 7'($urandom_range(0, 127));
        3: cfg = 7'($urandom_range(9, 63));
        default: cfg = 7'($urandom_range(2, 8));
      endcase
      no_idle = ($urandom_range(0, 3) == 0);
      set_keys_used(cfg);
      n = (cfg < 1) ? 1 : (cfg > MAX_KEYS) ? MAX_KEYS : cfg;
      acc = ($urandom_range(0, 3) == 0) ? 33'h0 : 33'($urandom_range(0, 32'h00FF_FFFF));
      for (int i = 0; i < n; i++) begin
        queue_item(write_item(i, acc[32] ? 32'hFFFF_FFFF : acc[31:0],
                              pick_value(), pick_value(), pick_value()));
        case ($urandom_range(0, 9))
          0: acc = acc + 33'($urandom_range(0, 1));
          1: acc = acc + 33'($urandom());
          default: acc = acc + 33'($urandom_range(1, 32'h0004_0000));
        endcase
      end
      nsamp = $urandom_range(5, 30);
      for (int j = 0; j < nsamp; j++) begin
        if ($urandom_range(0, 19) == 0)
          queue_item(write_item($urandom_range(0, 63), $urandom(),
                                pick_value(), pick_value(), pick_value()));
        else
          queue_item(sample_item(pick_sample(n)));
      end
    end

    while (pending_items.size() > 0 || in_valid_i || due_results.size() > 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("Ran %0d items: %0d samples, %0d interpolated, %0d clamped at a track end.",
             queued, samples_seen, interp_seen, edge_seen);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/kts_pkg.sv
sv/kts_cell.sv
sv/kts_lerp.sv
sv/keyframe_track_sampler.sv
sv/kts_checker.sv
tb/testbench.sv
